// File: rtl/core/guillotine_rect_packer_macros.svh
// assertion helpers shared by the packer
`ifndef GUILLOTINE_RECT_PACKER_MACROS_SVH
`define GUILLOTINE_RECT_PACKER_MACROS_SVH

// checked outside reset
`define GRP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GRP_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/grp_pkg.sv
package grp_pkg;

  localparam int MAX_SPACES_DEF = 256;
  localparam int COORD_BITS_DEF = 16;
  localparam int IN_W           = 16;

  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_FAILED = 2'd3;

  localparam logic CFG_BIN_WIDTH  = 1'b0;
  localparam logic CFG_BIN_HEIGHT = 1'b1;

  typedef struct packed {
    logic wr;
    logic shift;
    logic inject;
  } cell_ctl_t;

  typedef struct packed {
    logic act;
    logic found;
  } pkt_flags_t;

endpackage

// File: rtl/core/guillotine_rect_packer.sv
// channel  direction  handshake            payload
// in_      input      in_valid/in_stall    start_of_run, rect_width, rect_height
// out_     output     out_valid/out_stall  x_pos, y_pos, status
// cfg_     input      cfg_wr_en            cfg_index, cfg_wdata
// After a failed search no pieces are written; a placement erases the chosen space and appends
// 0..2 new pieces, and once the run failed, later items finish without a search.
// The fit search walks the full cell chain one cell per cycle, newest entry first.
// Reset is synchronous, active low; free entries hold garbage until written.
// A stalled result holds in the output register and delays only the finish of the next item.
module guillotine_rect_packer
  import grp_pkg::*;
#(
  parameter int MAX_SPACES = MAX_SPACES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_of_run,
  input  logic [15:0] in_rect_width,
  input  logic [15:0] in_rect_height,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_x_pos,
  output logic [15:0] out_y_pos,
  output logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_SPACES);
  localparam int CNT_W = $clog2(MAX_SPACES + 1);
  localparam int EW    = 4 * COORD_BITS;

  cell_ctl_t        ctl;
  logic [IDX_W-1:0] waddr, sel;
  logic [EW-1:0]    wdata;
  logic [CNT_W-1:0] count;
  logic [IN_W-1:0]  rw, rh;
  logic [EW-1:0]    ent [MAX_SPACES+1];
  pkt_flags_t       pflg [MAX_SPACES+1];
  logic [EW-1:0]    pent [MAX_SPACES+1];
  logic [IDX_W-1:0] psel [MAX_SPACES+1];

  assign ent[MAX_SPACES]  = '0;
  assign pflg[MAX_SPACES] = '{act: ctl.inject, found: 1'b0};
  assign pent[MAX_SPACES] = '0;
  assign psel[MAX_SPACES] = '0;

  for (genvar i = 0; i < MAX_SPACES; i++) begin : g_cell
    grp_cell #(
      .IDX(i), .CB(COORD_BITS), .IDX_W(IDX_W), .CNT_W(CNT_W)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .waddr(waddr), .wdata(wdata),
      .sel(sel), .count(count), .rw(rw), .rh(rh),
      .up_ent(ent[i+1]), .ent(ent[i]),
      .pin_flags(pflg[i+1]), .pin_ent(pent[i+1]), .pin_sel(psel[i+1]),
      .pout_flags(pflg[i]), .pout_ent(pent[i]), .pout_sel(psel[i])
    );
  end

  grp_ctl #(
    .MAX_SPACES(MAX_SPACES), .CB(COORD_BITS), .IDX_W(IDX_W), .CNT_W(CNT_W)
  ) u_ctl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_start_of_run(in_start_of_run),
    .in_rect_width(in_rect_width), .in_rect_height(in_rect_height),
    .out_valid(out_valid), .out_stall(out_stall), .out_x_pos(out_x_pos),
    .out_y_pos(out_y_pos), .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .ctl(ctl), .waddr(waddr), .wdata(wdata), .sel(sel), .count(count),
    .rw(rw), .rh(rh),
    .res_flags(pflg[0]), .res_ent(pent[0]), .res_sel(psel[0])
  );

endmodule

// File: rtl/core/grp_cell.sv
module grp_cell
  import grp_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int CB     = COORD_BITS_DEF,
  parameter int IDX_W  = 8,
  parameter int CNT_W  = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [4*CB-1:0]   wdata,
  input  logic [IDX_W-1:0]  sel,
  input  logic [CNT_W-1:0]  count,
  input  logic [IN_W-1:0]   rw,
  input  logic [IN_W-1:0]   rh,
  input  logic [4*CB-1:0]   up_ent,
  output logic [4*CB-1:0]   ent,
  input  pkt_flags_t        pin_flags,
  input  logic [4*CB-1:0]   pin_ent,
  input  logic [IDX_W-1:0]  pin_sel,
  output pkt_flags_t        pout_flags,
  output logic [4*CB-1:0]   pout_ent,
  output logic [IDX_W-1:0]  pout_sel
);

  logic [4*CB-1:0]  ent_r, ent_nxt;
  pkt_flags_t       flg_r, flg_nxt;
  logic [4*CB-1:0]  pent_r, pent_nxt;
  logic [IDX_W-1:0] psel_r, psel_nxt;
  logic [IN_W-1:0]  w16, h16;
  logic             live, fit;

  assign w16  = IN_W'(ent_r[CB-1+CB:CB]);
  assign h16  = IN_W'(ent_r[CB-1:0]);
  assign live = CNT_W'(IDX) < count;
  assign fit  = (w16 > rw && h16 > rh) || (w16 == rw && h16 >= rh) ||
                (h16 == rh && w16 >= rw);

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.wr && waddr == IDX_W'(IDX)) begin
      ent_nxt = wdata;
    end else if (ctl.shift && IDX_W'(IDX) >= sel) begin
      ent_nxt = up_ent;
    end
    flg_nxt  = pin_flags;
    pent_nxt = pin_ent;
    psel_nxt = pin_sel;
    if (pin_flags.act && !pin_flags.found && live && fit) begin
      flg_nxt.found = 1'b1;
      pent_nxt      = ent_r;
      psel_nxt      = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_r <= '0;
    end else begin
      flg_r <= flg_nxt;
    end
    ent_r  <= ent_nxt;
    pent_r <= pent_nxt;
    psel_r <= psel_nxt;
  end

  assign ent        = ent_r;
  assign pout_flags = flg_r;
  assign pout_ent   = pent_r;
  assign pout_sel   = psel_r;

endmodule

// File: rtl/core/grp_ctl.sv
`include "guillotine_rect_packer_macros.svh"
module grp_ctl
  import grp_pkg::*;
#(
  parameter int MAX_SPACES = MAX_SPACES_DEF,
  parameter int CB         = COORD_BITS_DEF,
  parameter int IDX_W      = 8,
  parameter int CNT_W      = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_start_of_run,
  input  logic [IN_W-1:0]   in_rect_width,
  input  logic [IN_W-1:0]   in_rect_height,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_x_pos,
  output logic [15:0]       out_y_pos,
  output logic [1:0]        out_status,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata,
  output cell_ctl_t         ctl,
  output logic [IDX_W-1:0]  waddr,
  output logic [4*CB-1:0]   wdata,
  output logic [IDX_W-1:0]  sel,
  output logic [CNT_W-1:0]  count,
  output logic [IN_W-1:0]   rw,
  output logic [IN_W-1:0]   rh,
  input  pkt_flags_t        res_flags,
  input  logic [4*CB-1:0]   res_ent,
  input  logic [IDX_W-1:0]  res_sel
);

  typedef enum logic [2:0] {
    S_IDLE, S_INJ, S_SEARCH, S_SHIFT, S_APP0, S_APP1, S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [15:0]      bw_r, bh_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             failed_r, failed_nxt;
  logic [IN_W-1:0]  rw_r, rw_nxt, rh_r, rh_nxt;
  logic [IDX_W-1:0] sel_r, sel_nxt;
  logic [1:0]       nmade_r, nmade_nxt, nmade_c;
  logic [4*CB-1:0]  m0_r, m0_nxt, m1_r, m1_nxt, m0_c, m1_c;
  logic [CB-1:0]    px_r, px_nxt, py_r, py_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             ov_r, ov_nxt;
  logic [15:0]      ox_r, ox_nxt, oy_r, oy_nxt;
  logic [1:0]       os_r, os_nxt;
  logic             accept;
  logic [CB-1:0]    sx, sy, sw, sh;
  logic [IN_W-1:0]  w16, h16, dw, dh;
  logic [CNT_W:0]   after_cnt;

  assign accept = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;

  assign sx  = res_ent[4*CB-1:3*CB];
  assign sy  = res_ent[3*CB-1:2*CB];
  assign sw  = res_ent[2*CB-1:CB];
  assign sh  = res_ent[CB-1:0];
  assign w16 = IN_W'(sw);
  assign h16 = IN_W'(sh);
  assign dw  = w16 - rw_r;
  assign dh  = h16 - rh_r;

  always_comb begin
    m0_c    = '0;
    m1_c    = '0;
    nmade_c = 2'd0;
    if (w16 > rw_r && h16 > rh_r) begin
      nmade_c = 2'd2;
      if (dh < dw) begin
        m0_c = {sx, sy + CB'(rh_r), sw, CB'(dh)};
        m1_c = {sx + CB'(rw_r), sy, CB'(dw), CB'(rh_r)};
      end else begin
        m0_c = {sx + CB'(rw_r), sy, CB'(dw), sh};
        m1_c = {sx, sy + CB'(rh_r), CB'(rw_r), CB'(dh)};
      end
    end else if (w16 == rw_r && h16 > rh_r) begin
      nmade_c = 2'd1;
      m0_c    = {sx, sy + CB'(rh_r), sw, CB'(dh)};
    end else if (h16 == rh_r && w16 > rw_r) begin
      nmade_c = 2'd1;
      m0_c    = {sx + CB'(rw_r), sy, CB'(dw), sh};
    end
  end

  assign after_cnt = (CNT_W+1)'(count_r) + (CNT_W+1)'(nmade_c) - (CNT_W+1)'(1);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    failed_nxt = failed_r;
    rw_nxt     = rw_r;
    rh_nxt     = rh_r;
    sel_nxt    = sel_r;
    nmade_nxt  = nmade_r;
    m0_nxt     = m0_r;
    m1_nxt     = m1_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    st_nxt     = st_r;
    ov_nxt     = ov_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    os_nxt     = os_r;
    ctl        = '0;
    waddr      = '0;
    wdata      = m0_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rw_nxt = in_rect_width;
          rh_nxt = in_rect_height;
          if (in_start_of_run) begin
            ctl.wr     = 1'b1;
            wdata      = {CB'(0), CB'(0), bw_r[CB-1:0], bh_r[CB-1:0]};
            count_nxt  = CNT_W'(1);
            failed_nxt = 1'b0;
            state_nxt  = S_INJ;
          end else if (failed_r) begin
            st_nxt    = ST_FAILED;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_INJ;
          end
        end
      end
      S_INJ: begin
        ctl.inject = 1'b1;
        state_nxt  = S_SEARCH;
      end
      S_SEARCH: begin
        if (res_flags.act) begin
          if (!res_flags.found) begin
            failed_nxt = 1'b1;
            st_nxt     = ST_NO_FIT;
            state_nxt  = S_FIN;
          end else if (after_cnt > (CNT_W+1)'(MAX_SPACES)) begin
            failed_nxt = 1'b1;
            st_nxt     = ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            sel_nxt   = res_sel;
            nmade_nxt = nmade_c;
            m0_nxt    = m0_c;
            m1_nxt    = m1_c;
            px_nxt    = sx;
            py_nxt    = sy;
            st_nxt    = ST_PLACED;
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        ctl.shift = 1'b1;
        count_nxt = count_r - CNT_W'(1);
        state_nxt = (nmade_r != 2'd0) ? S_APP0 : S_FIN;
      end
      S_APP0: begin
        ctl.wr    = 1'b1;
        waddr     = count_r[IDX_W-1:0];
        wdata     = m0_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = (nmade_r == 2'd2) ? S_APP1 : S_FIN;
      end
      S_APP1: begin
        ctl.wr    = 1'b1;
        waddr     = count_r[IDX_W-1:0];
        wdata     = m1_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          os_nxt    = st_r;
          ox_nxt    = (st_r == ST_PLACED) ? 16'(px_r) : 16'd0;
          oy_nxt    = (st_r == ST_PLACED) ? 16'(py_r) : 16'd0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      failed_r <= 1'b0;
      ov_r     <= 1'b0;
      bw_r     <= 16'd256;
      bh_r     <= 16'd256;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      failed_r <= failed_nxt;
      ov_r     <= ov_nxt;
      if (cfg_wr_en && cfg_index == CFG_BIN_WIDTH) begin
        bw_r <= cfg_wdata;
      end
      if (cfg_wr_en && cfg_index == CFG_BIN_HEIGHT) begin
        bh_r <= cfg_wdata;
      end
    end
    rw_r    <= rw_nxt;
    rh_r    <= rh_nxt;
    sel_r   <= sel_nxt;
    nmade_r <= nmade_nxt;
    m0_r    <= m0_nxt;
    m1_r    <= m1_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    st_r    <= st_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    os_r    <= os_nxt;
  end

  assign out_valid  = ov_r;
  assign out_x_pos  = ox_r;
  assign out_y_pos  = oy_r;
  assign out_status = os_r;
  assign sel        = sel_r;
  assign count      = count_r;
  assign rw         = rw_r;
  assign rh         = rh_r;

  `GRP_CHECK(a_count_max, count_r <= CNT_W'(MAX_SPACES), "free count above capacity")
  `GRP_CHECK(a_res_in_search, res_flags.act |-> state_r == S_SEARCH,
             "search result outside search")
  `GRP_CHECK(a_word_from_fin, $rose(ov_r) |-> $past(state_r == S_FIN),
             "result word without finish")
  `GRP_CHECK(a_fail_cause, $rose(failed_r) |-> $past(state_r == S_SEARCH),
             "failure set outside search")

endmodule
